// ===== rtl/pebb_pkg.sv =====
// ----------------------------------------------------------------------------
// pebb_pkg: shared types and constants of the particle Euler update block
// Holds the stage counts, fixed-point constants, register codes and the
// sideband record that travels with each particle through the pipeline.
// ----------------------------------------------------------------------------
package pebb_pkg;

	localparam int EU_STAGES  = 6;
	localparam int SQ_STAGES  = 31;
	localparam int DIV_STAGES = 31;
	localparam int BK_STAGES  = 7;
	localparam int LATENCY    = EU_STAGES + SQ_STAGES + DIV_STAGES + BK_STAGES;

	localparam logic signed [31:0] LOW_Y     = -32'sd3276800;
	localparam logic signed [31:0] RESPAWN_Y = 32'sd19660800;
	localparam logic signed [31:0] POS_BASE  = -32'sd3276800;
	localparam logic signed [31:0] POS_SCALE = 32'sd1600;
	localparam logic signed [31:0] VEL_BASE  = -32'sd655360;
	localparam logic signed [31:0] VEL_SCALE = 32'sd320;
	localparam logic signed [17:0] DAMP_Q16  = 18'sd52429;
	localparam logic signed [31:0] Q_ONE_30  = 32'sd1073741824;
	localparam logic [30:0]        DT_RESET  = 31'd1092;
	localparam logic [30:0]        AGE_MAX   = 31'h7fffffff;

	// Register index codes, taken from address bit 2.
	localparam logic REG_DT     = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] v;
		logic [2:0][62:0] pr;
		logic [30:0]      age;
		logic             last;
		logic             hit;
		logic             zero;
	} side_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'h7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'h80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/pebb_eu.sv =====
// ----------------------------------------------------------------------------
// pebb_eu: Euler integration, respawn and distance stages
// Six stages: velocity product, velocity sum, position product, position sum
// with respawn, squares and radius products, then the squared-distance test.
// ----------------------------------------------------------------------------
module pebb_eu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic [2:0][31:0]      pos,
	input  logic [2:0][31:0]      vel,
	input  logic [2:0][31:0]      acc,
	input  logic [30:0]           age_in,
	input  logic [59:0]           rnd,
	input  logic                  last,
	input  logic [30:0]           dt,
	input  logic [30:0]           radius,
	output logic                  out_vld,
	output logic [61:0]           d2,
	output pebb_pkg::side_t       side
);

	logic [6:1] vld_s;

	logic signed [63:0] pa_s1 [3];
	logic [2:0][31:0]   p_s1, v_s1;
	logic [30:0]        age_s1;
	logic [59:0]        rnd_s1;
	logic               last_s1;

	logic [2:0][31:0]   p_s2, v_s2;
	logic [30:0]        age_s2;
	logic [59:0]        rnd_s2;
	logic               last_s2;

	logic signed [63:0] pv_s3 [3];
	logic [2:0][31:0]   p_s3, v_s3;
	logic [30:0]        age_s3;
	logic [59:0]        rnd_s3;
	logic               last_s3;

	logic [2:0][31:0]   p_s4, v_s4;
	logic [30:0]        age_s4;
	logic               last_s4;

	logic [63:0]        sq_s5 [3];
	logic [2:0][62:0]   pr_s5;
	logic [61:0]        rr_s5;
	logic [2:0][31:0]   p_s5, v_s5;
	logic [30:0]        age_s5;
	logic               last_s5;

	logic [63:0]        d2_s6;
	pebb_pkg::side_t    side_s6;

	logic [31:0]        age_sum;
	logic [2:0][31:0]   p_new, p_rsp, v_rsp;
	logic [2:0][31:0]   mag;
	logic [63:0]        d2_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[5:1], in_vld};
		end
	end

	assign age_sum = {1'b0, age_in} + {1'b0, dt};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_new[i] = pebb_pkg::sat32(64'($signed(p_s3[i])) + (pv_s3[i] >>> 16));
		end
		p_rsp[0] = pebb_pkg::POS_BASE + $signed({20'd0, rnd_s3[11:0]}) * pebb_pkg::POS_SCALE;
		p_rsp[1] = pebb_pkg::RESPAWN_Y;
		p_rsp[2] = pebb_pkg::POS_BASE + $signed({20'd0, rnd_s3[23:12]}) * pebb_pkg::POS_SCALE;
		v_rsp[0] = pebb_pkg::VEL_BASE + $signed({20'd0, rnd_s3[35:24]}) * pebb_pkg::VEL_SCALE;
		v_rsp[1] = pebb_pkg::VEL_BASE + $signed({20'd0, rnd_s3[47:36]}) * pebb_pkg::VEL_SCALE;
		v_rsp[2] = pebb_pkg::VEL_BASE + $signed({20'd0, rnd_s3[59:48]}) * pebb_pkg::VEL_SCALE;
		for (int i = 0; i < 3; i++) begin
			mag[i] = p_s4[i][31] ? (32'd0 - p_s4[i]) : p_s4[i];
		end
		d2_sum = sq_s5[0] + sq_s5[1] + sq_s5[2];
	end

	always_ff @(posedge clk) begin
		// Stage 1: dt times acceleration.
		for (int i = 0; i < 3; i++) begin
			pa_s1[i] <= $signed({1'b0, dt}) * $signed(acc[i]);
		end
		p_s1    <= pos;
		v_s1    <= vel;
		age_s1  <= age_sum[31] ? pebb_pkg::AGE_MAX : age_sum[30:0];
		rnd_s1  <= rnd;
		last_s1 <= last;

		// Stage 2: new velocity.
		for (int i = 0; i < 3; i++) begin
			v_s2[i] <= pebb_pkg::sat32(64'($signed(v_s1[i])) + (pa_s1[i] >>> 16));
		end
		p_s2    <= p_s1;
		age_s2  <= age_s1;
		rnd_s2  <= rnd_s1;
		last_s2 <= last_s1;

		// Stage 3: dt times new velocity.
		for (int i = 0; i < 3; i++) begin
			pv_s3[i] <= $signed({1'b0, dt}) * $signed(v_s2[i]);
		end
		p_s3    <= p_s2;
		v_s3    <= v_s2;
		age_s3  <= age_s2;
		rnd_s3  <= rnd_s2;
		last_s3 <= last_s2;

		// Stage 4: new position, respawn below the floor.
		if ($signed(p_new[1]) < pebb_pkg::LOW_Y) begin
			p_s4 <= p_rsp;
			v_s4 <= v_rsp;
		end else begin
			p_s4 <= p_new;
			v_s4 <= v_s3;
		end
		age_s4  <= age_s3;
		last_s4 <= last_s3;

		// Stage 5: squares, radius squared, magnitude times radius.
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= 64'($signed(p_s4[i]) * $signed(p_s4[i]));
			pr_s5[i] <= 63'(mag[i]) * 63'(radius);
		end
		rr_s5   <= 62'(radius) * 62'(radius);
		p_s5    <= p_s4;
		v_s5    <= v_s4;
		age_s5  <= age_s4;
		last_s5 <= last_s4;

		// Stage 6: squared distance and the inside test.
		d2_s6          <= d2_sum;
		side_s6.p      <= p_s5;
		side_s6.v      <= v_s5;
		side_s6.pr     <= pr_s5;
		side_s6.age    <= age_s5;
		side_s6.last   <= last_s5;
		side_s6.hit    <= d2_sum < 64'(rr_s5);
		side_s6.zero   <= d2_sum == 64'd0;
	end

	assign out_vld = vld_s[6];
	assign d2      = d2_s6[61:0];
	assign side    = side_s6;

endmodule

// ===== rtl/pebb_sqrt.sv =====
// ----------------------------------------------------------------------------
// pebb_sqrt: pipelined integer square root
// One result bit per stage, most significant first, restoring form.
// ----------------------------------------------------------------------------
module pebb_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [61:0]     d2,
	input  pebb_pkg::side_t side_in,
	output logic            out_vld,
	output logic [30:0]     root,
	output pebb_pkg::side_t side_out
);

	localparam int N = pebb_pkg::SQ_STAGES;

	logic [61:0]     rem_s  [N+1];
	logic [30:0]     q_s    [N+1];
	pebb_pkg::side_t side_s [N+1];
	logic [N:0]      vld_s;

	assign rem_s[0]  = d2;
	assign q_s[0]    = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[N:1] <= '0;
		end else begin
			vld_s[N:1] <= vld_s[N-1:0];
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_stage
		localparam int B = N - k;
		logic [62:0] trial;

		// (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
		assign trial = (63'(q_s[k-1]) << (B + 1)) | (63'd1 << (2 * B));

		always_ff @(posedge clk) begin
			if ({1'b0, rem_s[k-1]} >= trial) begin
				rem_s[k] <= 62'({1'b0, rem_s[k-1]} - trial);
				q_s[k]   <= q_s[k-1] | (31'd1 << B);
			end else begin
				rem_s[k] <= rem_s[k-1];
				q_s[k]   <= q_s[k-1];
			end
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_vld  = vld_s[N];
	assign root     = q_s[N];
	assign side_out = side_s[N];

endmodule

// ===== rtl/pebb_div.sv =====
// ----------------------------------------------------------------------------
// pebb_div: six-lane pipelined restoring divider
// Lanes 0..2 give |p|*2^30/L (normal), lanes 3..5 give |p|*R/L (surface
// point), one quotient bit per stage.
// ----------------------------------------------------------------------------
module pebb_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [30:0]      len,
	input  pebb_pkg::side_t  side_in,
	output logic             out_vld,
	output logic [2:0][30:0] qn,
	output logic [2:0][30:0] qp,
	output pebb_pkg::side_t  side_out
);

	localparam int N = pebb_pkg::DIV_STAGES;

	logic [5:0][62:0] rem_s  [N+1];
	logic [5:0][30:0] q_s    [N+1];
	logic [30:0]      len_s  [N+1];
	pebb_pkg::side_t  side_s [N+1];
	logic [N:0]       vld_s;
	logic [2:0][31:0] mag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i]          = side_in.p[i][31] ? (32'd0 - side_in.p[i]) : side_in.p[i];
			rem_s[0][i]     = 63'(mag[i]) << 30;
			rem_s[0][i + 3] = side_in.pr[i];
		end
	end

	assign q_s[0]    = '0;
	assign len_s[0]  = len;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[N:1] <= '0;
		end else begin
			vld_s[N:1] <= vld_s[N-1:0];
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_stage
		localparam int B = N - k;
		logic [62:0] sub;

		assign sub = 63'(len_s[k-1]) << B;

		always_ff @(posedge clk) begin
			for (int j = 0; j < 6; j++) begin
				if (rem_s[k-1][j] >= sub) begin
					rem_s[k][j] <= rem_s[k-1][j] - sub;
					q_s[k][j]   <= q_s[k-1][j] | (31'd1 << B);
				end else begin
					rem_s[k][j] <= rem_s[k-1][j];
					q_s[k][j]   <= q_s[k-1][j];
				end
			end
			len_s[k]  <= len_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qn[i] = q_s[N][i];
			qp[i] = q_s[N][i + 3];
		end
	end

	assign out_vld  = vld_s[N];
	assign side_out = side_s[N];

endmodule

// ===== rtl/pebb_coll.sv =====
// ----------------------------------------------------------------------------
// pebb_coll: collision response stages
// Signs the normal and surface point, forms the dot product, reflects the
// velocity about the normal, damps it, and registers the final result.
// ----------------------------------------------------------------------------
module pebb_coll (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [2:0][30:0] qn,
	input  logic [2:0][30:0] qp,
	input  pebb_pkg::side_t  side_in,
	input  logic [30:0]      radius,
	output logic             out_vld,
	output logic [2:0][31:0] pos,
	output logic [2:0][31:0] vel,
	output logic [30:0]      age,
	output logic             last
);

	logic [7:1] vld_s;

	logic signed [31:0] n_s1  [3];
	logic [2:0][31:0]   ps_s1;
	pebb_pkg::side_t    sd_s1;

	logic signed [63:0] m_s2  [3];
	logic signed [31:0] n_s2  [3];
	logic [2:0][31:0]   ps_s2;
	pebb_pkg::side_t    sd_s2;

	logic signed [33:0] d_s3;
	logic signed [31:0] n_s3  [3];
	logic [2:0][31:0]   ps_s3;
	pebb_pkg::side_t    sd_s3;

	logic signed [65:0] dn_s4 [3];
	logic [2:0][31:0]   ps_s4;
	pebb_pkg::side_t    sd_s4;

	logic signed [36:0] rf_s5 [3];
	logic [2:0][31:0]   ps_s5;
	pebb_pkg::side_t    sd_s5;

	logic signed [54:0] rm_s6 [3];
	logic [2:0][31:0]   ps_s6;
	pebb_pkg::side_t    sd_s6;

	logic [2:0][31:0]   pos_s7, vel_s7;
	logic [30:0]        age_s7;
	logic               last_s7;

	logic signed [63:0] dot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[6:1], in_vld};
		end
	end

	assign dot = m_s2[0] + m_s2[1] + m_s2[2];

	always_ff @(posedge clk) begin
		// Stage 1: apply signs; a particle at the origin takes normal +y.
		for (int i = 0; i < 3; i++) begin
			if (side_in.zero) begin
				n_s1[i]  <= (i == 1) ? pebb_pkg::Q_ONE_30 : 32'sd0;
				ps_s1[i] <= (i == 1) ? {1'b0, radius} : 32'd0;
			end else if (side_in.p[i][31]) begin
				n_s1[i]  <= 32'sd0 - $signed({1'b0, qn[i]});
				ps_s1[i] <= 32'd0 - {1'b0, qp[i]};
			end else begin
				n_s1[i]  <= $signed({1'b0, qn[i]});
				ps_s1[i] <= {1'b0, qp[i]};
			end
		end
		sd_s1 <= side_in;

		// Stage 2: velocity times normal.
		for (int i = 0; i < 3; i++) begin
			m_s2[i] <= $signed(sd_s1.v[i]) * n_s1[i];
			n_s2[i] <= n_s1[i];
		end
		ps_s2 <= ps_s1;
		sd_s2 <= sd_s1;

		// Stage 3: dot product, back to Q16.16.
		d_s3 <= 34'(dot >>> 30);
		for (int i = 0; i < 3; i++) begin
			n_s3[i] <= n_s2[i];
		end
		ps_s3 <= ps_s2;
		sd_s3 <= sd_s2;

		// Stage 4: projection onto the normal.
		for (int i = 0; i < 3; i++) begin
			dn_s4[i] <= d_s3 * n_s3[i];
		end
		ps_s4 <= ps_s3;
		sd_s4 <= sd_s3;

		// Stage 5: reflected velocity (twice the projection, hence shift 29).
		for (int i = 0; i < 3; i++) begin
			rf_s5[i] <= 37'($signed(sd_s4.v[i])) - 37'(dn_s4[i] >>> 29);
		end
		ps_s5 <= ps_s4;
		sd_s5 <= sd_s4;

		// Stage 6: damping by 0.8.
		for (int i = 0; i < 3; i++) begin
			rm_s6[i] <= rf_s5[i] * pebb_pkg::DAMP_Q16;
		end
		ps_s6 <= ps_s5;
		sd_s6 <= sd_s5;

		// Stage 7: choose the collided or the free result.
		for (int i = 0; i < 3; i++) begin
			if (sd_s6.hit) begin
				pos_s7[i] <= ps_s6[i];
				vel_s7[i] <= pebb_pkg::sat32(64'(rm_s6[i] >>> 16));
			end else begin
				pos_s7[i] <= sd_s6.p[i];
				vel_s7[i] <= sd_s6.v[i];
			end
		end
		age_s7  <= sd_s6.age;
		last_s7 <= sd_s6.last;
	end

	assign out_vld = vld_s[7];
	assign pos     = pos_s7;
	assign vel     = vel_s7;
	assign age     = age_s7;
	assign last    = last_s7;

endmodule

// ===== rtl/particle_euler_sphere_bounce_top.sv =====
// ----------------------------------------------------------------------------
// particle_euler_sphere_bounce_top: streaming particle update pipeline
// One semi-implicit Euler step per particle with floor respawn and collision
// against an origin-centered sphere, in signed Q16.16.
// ----------------------------------------------------------------------------
// The block takes one particle request in every clock cycle: busy is never
// raised, so start alone decides when a request is accepted. Each request
// produces exactly one result, shown on the new_* ports for one cycle with
// done high, in request order. The receiver cannot stall the block, so it
// must take every result in the cycle that done is high. Most of the
// pipeline lies in the two units in the middle, each of which forms one
// result bit per stage: a 31-stage square root for the distance to the
// origin and a 31-stage divider that forms the normal and the surface
// point. Six stages before them integrate velocity and position, apply
// the respawn and test the sphere; seven stages after them reflect and
// damp the velocity. The time step and the sphere radius are written
// through the APB port and must only change while no request is in flight.
// ----------------------------------------------------------------------------
module particle_euler_sphere_bounce_top (
	input  logic        clk,
	input  logic        arst_n,

	// Request side.
	input  logic        start,
	output logic        busy,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [31:0] acc_x,
	input  logic [31:0] acc_y,
	input  logic [31:0] acc_z,
	input  logic [30:0] age_in,
	input  logic [59:0] random_bits,
	input  logic        last_particle,

	// Result side.
	output logic        done,
	output logic [31:0] new_pos_x,
	output logic [31:0] new_pos_y,
	output logic [31:0] new_pos_z,
	output logic [31:0] new_vel_x,
	output logic [31:0] new_vel_y,
	output logic [31:0] new_vel_z,
	output logic [30:0] age_out,
	output logic        last_out,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [30:0]      dt_step_q;
	logic [30:0]      sphere_radius_q;
	logic             accept;

	logic             eu_vld;
	logic [61:0]      eu_d2;
	pebb_pkg::side_t  eu_side;

	logic             sq_vld;
	logic [30:0]      sq_root;
	pebb_pkg::side_t  sq_side;

	logic             dv_vld;
	logic [2:0][30:0] dv_qn, dv_qp;
	pebb_pkg::side_t  dv_side;

	logic [2:0][31:0] res_pos, res_vel;

	// The pipeline never holds a request back.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Registers sit at byte addresses 0 and 4; address bit 2 picks one.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_step_q       <= pebb_pkg::DT_RESET;
			sphere_radius_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				pebb_pkg::REG_DT:     dt_step_q       <= pwdata[30:0];
				pebb_pkg::REG_RADIUS: sphere_radius_q <= pwdata[30:0];
				default:              dt_step_q       <= dt_step_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pebb_pkg::REG_DT:     prdata = {1'b0, dt_step_q};
			pebb_pkg::REG_RADIUS: prdata = {1'b0, sphere_radius_q};
			default:              prdata = '0;
		endcase
	end

	// Integration, respawn and the squared-distance test.
	pebb_eu u_eu (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.pos     ({pos_z, pos_y, pos_x}),
		.vel     ({vel_z, vel_y, vel_x}),
		.acc     ({acc_z, acc_y, acc_x}),
		.age_in  (age_in),
		.rnd     (random_bits),
		.last    (last_particle),
		.dt      (dt_step_q),
		.radius  (sphere_radius_q),
		.out_vld (eu_vld),
		.d2      (eu_d2),
		.side    (eu_side)
	);

	// Distance to the origin; only meaningful for particles inside.
	pebb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (eu_vld),
		.d2       (eu_d2),
		.side_in  (eu_side),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// Normal and surface point magnitudes.
	pebb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.len      (sq_root),
		.side_in  (sq_side),
		.out_vld  (dv_vld),
		.qn       (dv_qn),
		.qp       (dv_qp),
		.side_out (dv_side)
	);

	// Reflection, damping and the registered result.
	pebb_coll u_coll (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dv_vld),
		.qn      (dv_qn),
		.qp      (dv_qp),
		.side_in (dv_side),
		.radius  (sphere_radius_q),
		.out_vld (done),
		.pos     (res_pos),
		.vel     (res_vel),
		.age     (age_out),
		.last    (last_out)
	);

	assign new_pos_x = res_pos[0];
	assign new_pos_y = res_pos[1];
	assign new_pos_z = res_pos[2];
	assign new_vel_x = res_vel[0];
	assign new_vel_y = res_vel[1];
	assign new_vel_z = res_vel[2];

	// Every accepted request comes out after the fixed pipeline latency.
	a_req_to_done : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(pebb_pkg::LATENCY) done)
		else $error("accepted request produced no result");

	// No result appears without a request the fixed latency earlier.
	a_done_has_req : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, pebb_pkg::LATENCY))
		else $error("result without a matching request");

	// The frame marker travels unchanged with its request.
	a_last_follows : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> last_out == $past(last_particle, pebb_pkg::LATENCY))
		else $error("frame marker lost its request");

endmodule
